[hw/rtl/chbp_pkg.sv]
// Shared types and constants for the capture backend health policy block.
package chbp_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Fixed field widths.
  localparam int OPCODE_W = 3;
  localparam int SCORE_W  = 10;
  localparam int THR_W    = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_HW_SUPPORTED  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HW_ACTIVE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_BACKEND  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKED_USE_HW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEGRADE_MS    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FAIL_THR      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THR     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIP_THR     = 3'd7;

  // Register reset values.
  localparam logic [THR_W-1:0]   FAIL_THR_RESET  = 16'd3;
  localparam logic [SCORE_W-1:0] SCORE_THR_RESET = 10'd20;
  localparam logic [THR_W-1:0]   STRIP_THR_RESET = 16'd3;

  // Policy constants.
  localparam logic [SCORE_W-1:0] SCORE_MAX      = 10'd1000;
  localparam logic [SCORE_W:0]   EMPTY_STEP     = 11'd2;
  localparam logic [13:0]        STRIP_FORCE_MS = 14'd8000;

  // Event opcodes; the eighth code is unused and changes nothing.
  typedef enum logic [OPCODE_W-1:0] {
    OP_DECIDE   = 3'd0,
    OP_EMPTY    = 3'd1,
    OP_SUCCESS  = 3'd2,
    OP_SLOW     = 3'd3,
    OP_STRIP    = 3'd4,
    OP_NO_STRIP = 3'd5,
    OP_START    = 3'd6
  } op_t;

  // Configuration register contents.
  typedef struct packed {
    logic               hw_supported;
    logic               hw_active;
    logic               lock_backend;
    logic               locked_use_hw;
    logic [31:0]        degrade_ms;
    logic [THR_W-1:0]   fail_thr;
    logic [SCORE_W-1:0] score_thr;
    logic [THR_W-1:0]   strip_thr;
  } cfg_t;

endpackage

[hw/rtl/chbp_if.sv]
// Request and result channel interfaces of the capture backend health policy block.
interface chbp_event_if #(
  parameter int TIME_BITS = 48
);
  logic                         valid;
  logic                         ready;
  logic [chbp_pkg::OPCODE_W-1:0] opcode;
  logic [TIME_BITS-1:0]         now_ms;
  logic                         event_hw_flag;

  modport source (output valid, output opcode, output now_ms, output event_hw_flag,
                  input ready);
  modport sink (input valid, input opcode, input now_ms, input event_hw_flag,
                output ready);
endinterface

interface chbp_result_if;
  logic                         valid;
  logic                         ready;
  logic                         use_hw;
  logic                         reset_duplication;
  logic                         session_disabled;
  logic [chbp_pkg::SCORE_W-1:0] score_out;

  modport source (output valid, output use_hw, output reset_duplication,
                  output session_disabled, output score_out, input ready);
  modport sink (input valid, input use_hw, input reset_duplication,
                input session_disabled, input score_out, output ready);
endinterface

[hw/rtl/chbp_cfg_regs.sv]
// Configuration register file of the capture backend health policy block.
module chbp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [chbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [chbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output chbp_pkg::cfg_t                    cfg
);

  chbp_pkg::cfg_t cfg_q;

  // Write one register per enabled cycle; each keeps the low bits it needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.hw_supported  <= 1'b0;
      cfg_q.hw_active     <= 1'b0;
      cfg_q.lock_backend  <= 1'b0;
      cfg_q.locked_use_hw <= 1'b0;
      cfg_q.degrade_ms    <= '0;
      cfg_q.fail_thr      <= chbp_pkg::FAIL_THR_RESET;
      cfg_q.score_thr     <= chbp_pkg::SCORE_THR_RESET;
      cfg_q.strip_thr     <= chbp_pkg::STRIP_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chbp_pkg::REG_HW_SUPPORTED:  cfg_q.hw_supported  <= cfg_data[0];
        chbp_pkg::REG_HW_ACTIVE:     cfg_q.hw_active     <= cfg_data[0];
        chbp_pkg::REG_LOCK_BACKEND:  cfg_q.lock_backend  <= cfg_data[0];
        chbp_pkg::REG_LOCKED_USE_HW: cfg_q.locked_use_hw <= cfg_data[0];
        chbp_pkg::REG_DEGRADE_MS:    cfg_q.degrade_ms    <= cfg_data[31:0];
        chbp_pkg::REG_FAIL_THR:      cfg_q.fail_thr      <= cfg_data[chbp_pkg::THR_W-1:0];
        chbp_pkg::REG_SCORE_THR:     cfg_q.score_thr     <= cfg_data[chbp_pkg::SCORE_W-1:0];
        chbp_pkg::REG_STRIP_THR:     cfg_q.strip_thr     <= cfg_data[chbp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

[hw/rtl/capture_backend_health_policy_core.sv]
// Top level of the capture backend health policy block.
//
//   Channel | Direction | Handshake     | Contents
//   ev      | in        | valid/ready   | opcode, now_ms, event_hw_flag
//   res     | out       | valid/ready   | use_hw, reset_duplication, session_disabled, score_out
//   cfg     | in        | cfg_we only   | cfg_index, cfg_data (write only)
//
// One request per cycle is accepted while the result channel is not stalled. Its result is
// loaded into the result register when the request leaves the input register. The policy
// state is read and written in the single stage between the two registers, so consecutive
// requests see each other's updates. A stalled result holds the pipeline; ev.ready drops
// only when both registers are full and res.ready is low. Reset clears all state at once.
module capture_backend_health_policy_core #(
  parameter int TIME_BITS   = 48,
  parameter int STREAK_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [chbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  chbp_event_if.sink                       ev,
  chbp_result_if.source                    res
);

  localparam int CMP_W = (STREAK_BITS > chbp_pkg::THR_W) ? STREAK_BITS : chbp_pkg::THR_W;
  localparam logic [TIME_BITS-1:0]   TIME_ONES   = {TIME_BITS{1'b1}};
  localparam logic [STREAK_BITS-1:0] STREAK_ONES = {STREAK_BITS{1'b1}};

  chbp_pkg::cfg_t cfg;

  chbp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  logic                 s1_valid;
  chbp_pkg::op_t        s1_op;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_flag;

  // Result register.
  logic                         o_valid;
  logic                         o_use_hw;
  logic                         o_dup;
  logic                         o_dis;
  logic [chbp_pkg::SCORE_W-1:0] o_score;

  // Policy state and its next values.
  logic [TIME_BITS-1:0]         sw_hold_until, sw_hold_until_next;
  logic [STREAK_BITS-1:0]       fail_streak, fail_streak_next;
  logic [STREAK_BITS-1:0]       strip_streak, strip_streak_next;
  logic [chbp_pkg::SCORE_W-1:0] score, score_next;
  logic                         disabled_latch, disabled_latch_next;
  logic                         last_used_hw, last_used_hw_next;
  logic                         dup_next;

  logic advance;

  // The result register frees when empty or taken; the input register follows.
  assign advance  = !o_valid || res.ready;
  assign ev.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ev.ready) begin
      s1_valid <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid && ev.ready) begin
      s1_op   <= chbp_pkg::op_t'(ev.opcode);
      s1_now  <= ev.now_ms;
      s1_flag <= ev.event_hw_flag;
    end
  end

  // Saturating deadlines, saturating streak steps and score steps.
  logic [TIME_BITS:0]           degrade_sum, strip_sum;
  logic [TIME_BITS-1:0]         degrade_deadline, strip_deadline;
  logic [STREAK_BITS-1:0]       fail_up, strip_up, strip_down;
  logic [chbp_pkg::SCORE_W:0]   score_plus2, score_plus1;
  logic [chbp_pkg::SCORE_W-1:0] score_up2, score_up1, score_down;
  logic                         fail_hit, strip_hit;

  always_comb begin
    degrade_sum      = {1'b0, s1_now} + (TIME_BITS+1)'(cfg.degrade_ms);
    strip_sum        = {1'b0, s1_now} + (TIME_BITS+1)'(chbp_pkg::STRIP_FORCE_MS);
    degrade_deadline = degrade_sum[TIME_BITS] ? TIME_ONES : degrade_sum[TIME_BITS-1:0];
    strip_deadline   = strip_sum[TIME_BITS] ? TIME_ONES : strip_sum[TIME_BITS-1:0];

    fail_up    = (fail_streak == STREAK_ONES) ? STREAK_ONES : fail_streak + 1'b1;
    strip_up   = (strip_streak == STREAK_ONES) ? STREAK_ONES : strip_streak + 1'b1;
    strip_down = (strip_streak == '0) ? '0 : strip_streak - 1'b1;
    fail_hit   = CMP_W'(fail_up) >= CMP_W'(cfg.fail_thr);
    strip_hit  = CMP_W'(strip_up) >= CMP_W'(cfg.strip_thr);

    score_plus2 = {1'b0, score} + chbp_pkg::EMPTY_STEP;
    score_plus1 = {1'b0, score} + 1'b1;
    score_up2   = (score_plus2 > {1'b0, chbp_pkg::SCORE_MAX}) ? chbp_pkg::SCORE_MAX
                                                                : score_plus2[chbp_pkg::SCORE_W-1:0];
    score_up1   = (score_plus1 > {1'b0, chbp_pkg::SCORE_MAX}) ? chbp_pkg::SCORE_MAX
                                                                : score_plus1[chbp_pkg::SCORE_W-1:0];
    score_down  = (score == '0) ? '0 : score - 1'b1;
  end

  // Per-opcode state update.
  always_comb begin
    sw_hold_until_next  = sw_hold_until;
    fail_streak_next    = fail_streak;
    strip_streak_next   = strip_streak;
    score_next          = score;
    disabled_latch_next = disabled_latch;
    last_used_hw_next   = last_used_hw;
    dup_next            = 1'b0;
    unique case (s1_op)
      chbp_pkg::OP_DECIDE: begin
        if (cfg.lock_backend) begin
          last_used_hw_next = cfg.hw_supported && cfg.locked_use_hw;
        end else begin
          last_used_hw_next = cfg.hw_active && !disabled_latch && (s1_now >= sw_hold_until);
        end
      end
      chbp_pkg::OP_EMPTY: begin
        score_next = score_up2;
        if (fail_hit) begin
          fail_streak_next = '0;
          dup_next         = 1'b1;
        end else begin
          fail_streak_next = fail_up;
        end
        if (!cfg.lock_backend) begin
          sw_hold_until_next = degrade_deadline;
          if (score_up2 >= cfg.score_thr) begin
            disabled_latch_next = 1'b1;
          end
        end
      end
      chbp_pkg::OP_SUCCESS: begin
        fail_streak_next = '0;
        score_next       = score_down;
      end
      chbp_pkg::OP_SLOW: begin
        if (s1_flag && !cfg.lock_backend) begin
          score_next         = score_up1;
          sw_hold_until_next = degrade_deadline;
          if (score_up1 >= cfg.score_thr) begin
            disabled_latch_next = 1'b1;
          end
        end
      end
      chbp_pkg::OP_STRIP: begin
        strip_streak_next = strip_up;
        if (s1_flag) begin
          sw_hold_until_next = strip_deadline;
        end
        if (strip_hit) begin
          disabled_latch_next = 1'b1;
        end
      end
      chbp_pkg::OP_NO_STRIP: begin
        strip_streak_next = strip_down;
      end
      chbp_pkg::OP_START: begin
        sw_hold_until_next  = '0;
        fail_streak_next    = '0;
        strip_streak_next   = '0;
        score_next          = '0;
        disabled_latch_next = 1'b0;
        last_used_hw_next   = 1'b0;
      end
      default: ;
    endcase
  end

  // State commits when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_hold_until  <= '0;
      fail_streak    <= '0;
      strip_streak   <= '0;
      score          <= '0;
      disabled_latch <= 1'b0;
      last_used_hw   <= 1'b0;
    end else if (s1_valid && advance) begin
      sw_hold_until  <= sw_hold_until_next;
      fail_streak    <= fail_streak_next;
      strip_streak   <= strip_streak_next;
      score          <= score_next;
      disabled_latch <= disabled_latch_next;
      last_used_hw   <= last_used_hw_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      o_use_hw <= last_used_hw_next;
      o_dup    <= dup_next;
      o_dis    <= disabled_latch_next;
      o_score  <= score_next;
    end
  end

  assign res.valid             = o_valid;
  assign res.use_hw            = o_use_hw;
  assign res.reset_duplication = o_dup;
  assign res.session_disabled  = o_dis;
  assign res.score_out         = o_score;

endmodule

[sim/tb_capture_backend_health_policy_core.sv]
// Self-checking testbench for the capture backend health policy core.
`timescale 1ns / 1ps

module tb_capture_backend_health_policy_core;
  import chbp_pkg::*;

  localparam int TIME_W = 48;
  localparam int STREAK_W = 16;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [STREAK_W-1:0] STREAK_TOP = '1;
  localparam logic [SCORE_W:0] SLOW_STEP = 11'd1;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 47;

  // One result as the block reports it.
  typedef struct packed {
    logic               use_hw;
    logic               reset_dup;
    logic               disabled;
    logic [SCORE_W-1:0] score;
  } health_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  chbp_event_if #(.TIME_BITS(TIME_W)) ev_ch ();
  chbp_result_if res_ch ();

  capture_backend_health_policy_core #(
    .TIME_BITS(TIME_W),
    .STREAK_BITS(STREAK_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .ev(ev_ch),
    .res(res_ch)
  );

  // Shadow of the configuration registers and of the policy state.
  cfg_t policy_cfg;
  logic [TIME_W-1:0] sw_deadline;
  logic [STREAK_W-1:0] empty_streak;
  logic [STREAK_W-1:0] strip_run;
  logic [SCORE_W-1:0] health_score;
  logic session_off;
  logic last_hw;

  health_t pending_results[$];
  int mismatches;
  bit idle_on;
  bit stall_on;
  logic [TIME_W-1:0] clock_ms;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [TIME_W-1:0] deadline_from(logic [TIME_W-1:0] now,
                                                      logic [31:0] delay);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W + 1 - 32){1'b0}}, delay};
    return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
  endfunction

  function automatic logic [STREAK_W-1:0] streak_inc(logic [STREAK_W-1:0] s);
    return (s == STREAK_TOP) ? s : s + 1'b1;
  endfunction

  function automatic logic [SCORE_W-1:0] score_add(logic [SCORE_W-1:0] s,
                                                   logic [SCORE_W:0] step);
    logic [SCORE_W:0] sum;
    sum = {1'b0, s} + step;
    return (sum > SCORE_MAX) ? SCORE_MAX : sum[SCORE_W-1:0];
  endfunction

  function automatic void clear_health_state();
    sw_deadline = '0;
    empty_streak = '0;
    strip_run = '0;
    health_score = '0;
    session_off = 1'b0;
    last_hw = 1'b0;
  endfunction

  // Applies one event to the shadow state and returns the result it should produce.
  function automatic health_t apply_event(logic [OPCODE_W-1:0] op, logic [TIME_W-1:0] now,
                                          logic flag);
    health_t r;
    logic dup;
    dup = 1'b0;
    case (op)
      OP_DECIDE: begin
        if (policy_cfg.lock_backend)
          last_hw = policy_cfg.hw_supported & policy_cfg.locked_use_hw;
        else
          last_hw = policy_cfg.hw_active & ~session_off & (now >= sw_deadline);
      end
      OP_EMPTY: begin
        empty_streak = streak_inc(empty_streak);
        health_score = score_add(health_score, EMPTY_STEP);
        if (empty_streak >= policy_cfg.fail_thr) begin
          empty_streak = '0;
          dup = 1'b1;
        end
        if (!policy_cfg.lock_backend) begin
          sw_deadline = deadline_from(now, policy_cfg.degrade_ms);
          if (health_score >= policy_cfg.score_thr) session_off = 1'b1;
        end
      end
      OP_SUCCESS: begin
        empty_streak = '0;
        if (health_score != '0) health_score = health_score - 1'b1;
      end
      OP_SLOW: begin
        if (flag && !policy_cfg.lock_backend) begin
          health_score = score_add(health_score, SLOW_STEP);
          sw_deadline = deadline_from(now, policy_cfg.degrade_ms);
          if (health_score >= policy_cfg.score_thr) session_off = 1'b1;
        end
      end
      OP_STRIP: begin
        strip_run = streak_inc(strip_run);
        if (flag) sw_deadline = deadline_from(now, {18'd0, STRIP_FORCE_MS});
        if (strip_run >= policy_cfg.strip_thr) session_off = 1'b1;
      end
      OP_NO_STRIP: begin
        if (strip_run != '0) strip_run = strip_run - 1'b1;
      end
      OP_START: begin
        clear_health_state();
      end
      default: begin
      end
    endcase
    r.use_hw = last_hw;
    r.reset_dup = dup;
    r.disabled = session_off;
    r.score = health_score;
    return r;
  endfunction

  function automatic void log_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Writes one configuration register and mirrors it in the shadow copy.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HW_SUPPORTED:  policy_cfg.hw_supported = data[0];
      REG_HW_ACTIVE:     policy_cfg.hw_active = data[0];
      REG_LOCK_BACKEND:  policy_cfg.lock_backend = data[0];
      REG_LOCKED_USE_HW: policy_cfg.locked_use_hw = data[0];
      REG_DEGRADE_MS:    policy_cfg.degrade_ms = data;
      REG_FAIL_THR:      policy_cfg.fail_thr = data[THR_W-1:0];
      REG_SCORE_THR:     policy_cfg.score_thr = data[SCORE_W-1:0];
      REG_STRIP_THR:     policy_cfg.strip_thr = data[THR_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Sends one request, with an optional idle burst ahead of it.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [TIME_W-1:0] now,
                              input logic flag);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      ev_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.opcode <= op;
    ev_ch.now_ms <= now;
    ev_ch.event_hw_flag <= flag;
    do @(posedge clk); while (!ev_ch.ready);
    pending_results.push_back(apply_event(op, now, flag));
  endtask

  // Lets the block drain so that the configuration can change safely.
  task automatic wait_quiet();
    @(negedge clk);
    ev_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register reset values with no writes yet.
  task automatic test_reset_defaults();
    send_request(OP_DECIDE, 48'd0, 1'b1);
    repeat (3) send_request(OP_EMPTY, 48'd10, 1'b0);
    send_request(OP_SLOW, 48'd20, 1'b1);
    send_request(OP_UNUSED, 48'd30, 1'b1);
    send_request(OP_SUCCESS, 48'd40, 1'b0);
    send_request(OP_NO_STRIP, 48'd50, 1'b0);
    repeat (3) send_request(OP_STRIP, 48'd60, 1'b0);
    send_request(OP_START, 48'd70, 1'b0);
    wait_quiet();
  endtask

  // Deadlines from empty, slow and strip events, including the saturated deadline.
  task automatic test_deadlines();
    write_reg(REG_HW_SUPPORTED, 32'd1);
    write_reg(REG_HW_ACTIVE, 32'd1);
    write_reg(REG_DEGRADE_MS, 32'd100);
    send_request(OP_DECIDE, 48'd0, 1'b0);
    send_request(OP_EMPTY, 48'd50, 1'b0);
    send_request(OP_DECIDE, 48'd149, 1'b0);
    send_request(OP_DECIDE, 48'd150, 1'b0);
    send_request(OP_SLOW, 48'd500, 1'b0);
    send_request(OP_SLOW, 48'd1000, 1'b1);
    send_request(OP_DECIDE, 48'd1099, 1'b0);
    send_request(OP_STRIP, 48'd2000, 1'b1);
    send_request(OP_DECIDE, 48'd9999, 1'b0);
    send_request(OP_DECIDE, 48'd10000, 1'b0);
    send_request(OP_NO_STRIP, 48'd10001, 1'b0);
    send_request(OP_NO_STRIP, 48'd10002, 1'b0);
    send_request(OP_SUCCESS, 48'd10003, 1'b0);
    send_request(OP_EMPTY, TIME_TOP - 48'd10, 1'b0);
    send_request(OP_DECIDE, TIME_TOP - 48'd1, 1'b0);
    send_request(OP_DECIDE, TIME_TOP, 1'b0);
    send_request(OP_STRIP, TIME_TOP - 48'd5, 1'b1);
    send_request(OP_DECIDE, TIME_TOP, 1'b0);
    send_request(OP_START, 48'd0, 1'b0);
    send_request(OP_DECIDE, 48'd0, 1'b0);
    wait_quiet();
  endtask

  // Lock mode pins the choice and keeps empty and slow events from moving the deadline.
  task automatic test_lock_mode();
    write_reg(REG_LOCK_BACKEND, 32'd1);
    write_reg(REG_LOCKED_USE_HW, 32'd1);
    send_request(OP_EMPTY, 48'd100, 1'b0);
    send_request(OP_SLOW, 48'd110, 1'b1);
    send_request(OP_DECIDE, 48'd120, 1'b0);
    send_request(OP_STRIP, 48'd130, 1'b1);
    send_request(OP_DECIDE, 48'd140, 1'b0);
    wait_quiet();
    write_reg(REG_HW_SUPPORTED, 32'd0);
    send_request(OP_DECIDE, 48'd150, 1'b0);
    send_request(OP_EMPTY, 48'd160, 1'b0);
    wait_quiet();
    write_reg(REG_HW_SUPPORTED, 32'd1);
    write_reg(REG_LOCK_BACKEND, 32'd0);
    send_request(OP_START, 48'd200, 1'b0);
    send_request(OP_DECIDE, 48'd210, 1'b0);
    wait_quiet();
  endtask

  // Zero thresholds are always reached; the largest ones are not.
  task automatic test_threshold_extremes();
    write_reg(REG_FAIL_THR, 32'd0);
    write_reg(REG_SCORE_THR, 32'd0);
    write_reg(REG_STRIP_THR, 32'd0);
    write_reg(REG_DEGRADE_MS, 32'hFFFF_FFFF);
    send_request(OP_EMPTY, 48'd5, 1'b0);
    send_request(OP_DECIDE, 48'd6, 1'b0);
    send_request(OP_START, 48'd7, 1'b0);
    send_request(OP_NO_STRIP, 48'd8, 1'b0);
    send_request(OP_STRIP, 48'd9, 1'b0);
    send_request(OP_START, 48'd10, 1'b0);
    send_request(OP_SLOW, 48'hFFFF_0000_0000, 1'b1);
    send_request(OP_DECIDE, TIME_TOP, 1'b0);
    wait_quiet();
    write_reg(REG_FAIL_THR, 32'd65535);
    write_reg(REG_SCORE_THR, 32'd1000);
    write_reg(REG_STRIP_THR, 32'd65535);
    send_request(OP_START, 48'd0, 1'b0);
    repeat (4) send_request(OP_EMPTY, 48'd20, 1'b0);
    repeat (4) send_request(OP_STRIP, 48'd30, 1'b0);
    send_request(OP_DECIDE, TIME_TOP, 1'b0);
    wait_quiet();
  endtask

  // The score stops at its ceiling and comes back down on success.
  task automatic test_score_saturation();
    write_reg(REG_DEGRADE_MS, 32'd0);
    send_request(OP_START, 48'd0, 1'b0);
    for (int i = 0; i < 505; i++) send_request(OP_EMPTY, 48'(i), 1'b0);
    send_request(OP_SLOW, 48'd600, 1'b1);
    repeat (2) send_request(OP_SUCCESS, 48'd601, 1'b0);
    send_request(OP_START, 48'd602, 1'b0);
    wait_quiet();
  endtask

  // Picks a configuration: the first phases use the extremes, the rest random values.
  task automatic pick_config(input int phase);
    logic [31:0] degrade;
    logic [15:0] fail_thr;
    logic [9:0] score_thr;
    logic [15:0] strip_thr;
    case (phase)
      0: begin
        degrade = 32'hFFFF_FFFF;
        fail_thr = 16'hFFFF;
        score_thr = 10'd1000;
        strip_thr = 16'hFFFF;
      end
      1: begin
        degrade = 32'd0;
        fail_thr = 16'd0;
        score_thr = 10'd0;
        strip_thr = 16'd0;
      end
      default: begin
        degrade = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 5000));
        fail_thr = 16'($urandom_range(1, 8));
        score_thr = 10'($urandom_range(1, 60));
        strip_thr = 16'($urandom_range(1, 6));
      end
    endcase
    write_reg(REG_HW_SUPPORTED, ($urandom_range(0, 3) == 0) ? $urandom : {$urandom} | 32'd1);
    write_reg(REG_HW_ACTIVE, ($urandom_range(0, 3) == 0) ? $urandom : {$urandom} | 32'd1);
    write_reg(REG_LOCK_BACKEND, ($urandom_range(0, 2) == 0) ? {$urandom} | 32'd1
                                                            : {$urandom} & ~32'd1);
    write_reg(REG_LOCKED_USE_HW, $urandom);
    write_reg(REG_DEGRADE_MS, degrade);
    write_reg(REG_FAIL_THR, {16'($urandom), fail_thr});
    write_reg(REG_SCORE_THR, {22'($urandom), score_thr});
    write_reg(REG_STRIP_THR, {16'($urandom), strip_thr});
  endtask

  // Mostly a session timeline that moves forward, with random jumps and noise.
  task automatic send_random_request();
    logic [OPCODE_W-1:0] op;
    logic [TIME_W-1:0] now;
    logic [63:0] rnd;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) op = OP_DECIDE;
    else if (pick < 45) op = OP_EMPTY;
    else if (pick < 60) op = OP_SUCCESS;
    else if (pick < 72) op = OP_SLOW;
    else if (pick < 83) op = OP_STRIP;
    else if (pick < 93) op = OP_NO_STRIP;
    else if (pick < 96) op = OP_START;
    else op = OP_UNUSED;
    pick = $urandom_range(0, 19);
    rnd = {$urandom, $urandom};
    if (pick == 0) begin
      now = rnd[TIME_W-1:0];
    end else if (pick == 1) begin
      now = TIME_TOP - 48'($urandom_range(0, 20000));
    end else begin
      clock_ms = clock_ms + 48'($urandom_range(0, 1500));
      now = clock_ms;
    end
    send_request(op, now, 1'($urandom));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase != RANDOM_PHASES - 1);
      stall_on = (phase != RANDOM_PHASES - 1);
      pick_config(phase);
      clock_ms = 48'($urandom_range(0, 100000));
      for (int i = 0; i < PHASE_REQUESTS; i++) send_random_request();
      wait_quiet();
    end
  endtask

  // Result ready, with random stall bursts.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 17);
        res_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk) begin : check_results
    health_t want;
    health_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.use_hw, res_ch.reset_duplication, res_ch.session_disabled,
             res_ch.score_out};
      if (pending_results.size() == 0) begin
        log_failure($sformatf("Unexpected result: use_hw=%b dup=%b disabled=%b score=%0d",
                              got.use_hw, got.reset_dup, got.disabled, got.score));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          log_failure($sformatf({"Mismatch: expected use_hw=%b dup=%b disabled=%b ",
                                 "score=%0d, got use_hw=%b dup=%b disabled=%b score=%0d"},
                                want.use_hw, want.reset_dup, want.disabled, want.score,
                                got.use_hw, got.reset_dup, got.disabled, got.score));
      end
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ev_ch.valid = 1'b0;
    ev_ch.opcode = '0;
    ev_ch.now_ms = '0;
    ev_ch.event_hw_flag = 1'b0;
    mismatches = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    clock_ms = '0;
    policy_cfg = '0;
    policy_cfg.fail_thr = FAIL_THR_RESET;
    policy_cfg.score_thr = SCORE_THR_RESET;
    policy_cfg.strip_thr = STRIP_THR_RESET;
    clear_health_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_deadlines();
    test_lock_mode();
    test_threshold_extremes();
    test_score_saturation();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
